### design/tvs_pkg.sv
// ----------------------------------------------------------------------------
// tvs_pkg
// shared types, constants and the linear blend used by the volume sampler
// ----------------------------------------------------------------------------
`default_nettype none

package tvs_pkg;

    localparam int COORD_W     = 32;
    localparam int SAMPLE_W    = 16;
    localparam int FRAC_W      = 16;
    localparam int ADDR_W      = 12;
    localparam int STORE_DEPTH = 4096;
    localparam int CORNERS     = 8;
    localparam int CFG_IDX_W   = 3;

    localparam int GRID_X_DEF  = 16;
    localparam int GRID_Y_DEF  = 16;
    localparam int GRID_Z_DEF  = 16;

    typedef enum logic
    {
        KIND_WRITE = 1'b0,
        KIND_QUERY = 1'b1
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_MIN_X = 3'd0,
        REG_MIN_Y = 3'd1,
        REG_MIN_Z = 3'd2,
        REG_MAX_X = 3'd3,
        REG_MAX_Y = 3'd4,
        REG_MAX_Z = 3'd5
    } cfg_reg_t;

    // a + round((b - a) * f / 2^16), same as (a*(1-f) + b*f) rounded half up
    function automatic logic [SAMPLE_W-1:0] blend(input logic [SAMPLE_W-1:0] a,
                                                 input logic [SAMPLE_W-1:0] b,
                                                 input logic [FRAC_W-1:0]   f);
        logic signed [SAMPLE_W:0]          diff;
        logic signed [SAMPLE_W+FRAC_W+1:0] prod;
        logic signed [SAMPLE_W+FRAC_W+1:0] sum;
        diff = $signed({1'b0, b}) - $signed({1'b0, a});
        prod = diff * $signed({1'b0, f});
        sum  = prod + $signed((SAMPLE_W+FRAC_W+2)'(32768)) + $signed({2'b00, a, 16'h0000});
        return sum[FRAC_W +: SAMPLE_W];
    endfunction

endpackage

`default_nettype wire

### design/trilinear_volume_sampler.sv
// ----------------------------------------------------------------------------
// trilinear_volume_sampler
// density grid store with trilinear sampling of q16.16 positions in a box
// ----------------------------------------------------------------------------
// throughput: one transaction per cycle while the result stream is not stalled; the
//   per-axis divider is fully pipelined and the eight corner reads go to eight
//   replicated store banks
// reset: box resets to [0, 1] on each axis, running peak to zero, pipeline empty;
//   the sample store is not cleared and holds garbage until written
`default_nettype none

module trilinear_volume_sampler import tvs_pkg::*; #(
    parameter int GRID_X = GRID_X_DEF,
    parameter int GRID_Y = GRID_Y_DEF,
    parameter int GRID_Z = GRID_Z_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // config write channel
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [COORD_W-1:0]   cfg_data,
    // input stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [127:0]         s_axis_tdata,  // sample_index, sample_value, pos_x, pos_y, pos_z
    input  wire logic                 s_axis_tuser,  // kind
    // result stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [31:0]               m_axis_tdata,  // density_out, peak_density
    output logic                      m_axis_tuser   // inside_res
);

    localparam int LWX = $clog2(GRID_X);
    localparam int LWY = $clog2(GRID_Y);
    localparam int LWZ = $clog2(GRID_Z);
    localparam int LWM = (LWX > LWY) ? ((LWX > LWZ) ? LWX : LWZ)
                                     : ((LWY > LWZ) ? LWY : LWZ);
    localparam int QW  = FRAC_W + LWM;
    localparam int LAT = QW + 3;     // axis unit depth
    localparam logic [ADDR_W-1:0] GX_A = ADDR_W'(GRID_X);
    localparam logic [ADDR_W-1:0] GY_A = ADDR_W'(GRID_Y);

    // input fields
    logic [ADDR_W-1:0]          in_idx;
    logic [SAMPLE_W-1:0]        in_val;
    logic signed [COORD_W-1:0]  in_px, in_py, in_pz;

    assign in_idx = s_axis_tdata[11:0];
    assign in_val = s_axis_tdata[27:12];
    assign in_px  = s_axis_tdata[59:28];
    assign in_py  = s_axis_tdata[91:60];
    assign in_pz  = s_axis_tdata[123:92];

    // whole pipeline advances together; the skid entry gives one spare slot
    logic en;
    logic sv_reg;
    assign en            = !sv_reg;
    assign s_axis_tready = en;

    // ---------------- box registers
    logic signed [COORD_W-1:0] min_x_reg, min_y_reg, min_z_reg;
    logic signed [COORD_W-1:0] max_x_reg, max_y_reg, max_z_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_x_reg <= '0;
            min_y_reg <= '0;
            min_z_reg <= '0;
            max_x_reg <= COORD_W'(65536);
            max_y_reg <= COORD_W'(65536);
            max_z_reg <= COORD_W'(65536);
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_MIN_X: min_x_reg <= cfg_data;
                REG_MIN_Y: min_y_reg <= cfg_data;
                REG_MIN_Z: min_z_reg <= cfg_data;
                REG_MAX_X: max_x_reg <= cfg_data;
                REG_MAX_Y: max_y_reg <= cfg_data;
                REG_MAX_Z: max_z_reg <= cfg_data;
                default:   ;  // writes past the last register are dropped
            endcase
        end
    end

    // ---------------- per-axis locate units
    logic              in_x, in_y, in_z;
    logic [LWX-1:0]    lx, ux;
    logic [LWY-1:0]    ly, uy;
    logic [LWZ-1:0]    lz, uz;
    logic [FRAC_W-1:0] fx, fy, fz;

    tvs_axis #(.G(GRID_X), .QW(QW)) u_axis_x (
        .clk(clk), .en(en), .pos(in_px), .lo(min_x_reg), .hi(max_x_reg),
        .in_box(in_x), .lower(lx), .upper(ux), .frac(fx)
    );
    tvs_axis #(.G(GRID_Y), .QW(QW)) u_axis_y (
        .clk(clk), .en(en), .pos(in_py), .lo(min_y_reg), .hi(max_y_reg),
        .in_box(in_y), .lower(ly), .upper(uy), .frac(fy)
    );
    tvs_axis #(.G(GRID_Z), .QW(QW)) u_axis_z (
        .clk(clk), .en(en), .pos(in_pz), .lo(min_z_reg), .hi(max_z_reg),
        .in_box(in_z), .lower(lz), .upper(uz), .frac(fz)
    );

    // ---------------- side delay line, kept in step with the axis units
    logic                v_pipe_reg [LAT];
    logic                k_pipe_reg [LAT];
    logic [ADDR_W-1:0]   a_pipe_reg [LAT];
    logic [SAMPLE_W-1:0] d_pipe_reg [LAT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                v_pipe_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_pipe_reg[0] <= s_axis_tvalid;
            for (int i = 1; i < LAT; i++)
            begin
                v_pipe_reg[i] <= v_pipe_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k_pipe_reg[0] <= s_axis_tuser;
            a_pipe_reg[0] <= in_idx;
            d_pipe_reg[0] <= in_val;
            for (int i = 1; i < LAT; i++)
            begin
                k_pipe_reg[i] <= k_pipe_reg[i-1];
                a_pipe_reg[i] <= a_pipe_reg[i-1];
                d_pipe_reg[i] <= d_pipe_reg[i-1];
            end
        end
    end

    // ---------------- corner addresses, wrapped to the store size
    // corner bit 0 picks upper x, bit 1 upper y, bit 2 upper z
    logic [ADDR_W-1:0]   ra_next [CORNERS];
    logic [ADDR_W-1:0]   ra_reg  [CORNERS];
    logic                vb_reg, kb_reg, inb_reg;
    logic [ADDR_W-1:0]   wa_reg;
    logic [SAMPLE_W-1:0] wv_reg;
    logic [FRAC_W-1:0]   fxb_reg, fyb_reg, fzb_reg;

    always_comb
    begin
        for (int c = 0; c < CORNERS; c++)
        begin
            ra_next[c] = ADDR_W'(c[0] ? ux : lx)
                       + GX_A * (ADDR_W'(c[1] ? uy : ly) + GY_A * ADDR_W'(c[2] ? uz : lz));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            vb_reg <= v_pipe_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kb_reg  <= k_pipe_reg[LAT-1];
            wa_reg  <= a_pipe_reg[LAT-1];
            wv_reg  <= d_pipe_reg[LAT-1];
            inb_reg <= in_x && in_y && in_z;
            fxb_reg <= fx;
            fyb_reg <= fy;
            fzb_reg <= fz;
            for (int c = 0; c < CORNERS; c++)
            begin
                ra_reg[c] <= ra_next[c];
            end
        end
    end

    // ---------------- store banks: every write goes to all eight copies
    logic                store_we;
    logic [SAMPLE_W-1:0] rd [CORNERS];

    assign store_we = en && vb_reg && (kb_reg == KIND_WRITE);

    for (genvar c = 0; c < CORNERS; c++)
    begin : g_bank
        tvs_ram #(.WIDTH(SAMPLE_W), .DEPTH(STORE_DEPTH)) u_bank (
            .clk(clk), .we(store_we), .waddr(wa_reg), .wdata(wv_reg),
            .re(en), .raddr(ra_reg[c]), .rdata(rd[c])
        );
    end

    // running peak, updated in order with the store writes
    logic [SAMPLE_W-1:0] peak_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_reg <= '0;
        end
        else if (store_we && (wv_reg > peak_reg))
        begin
            peak_reg <= wv_reg;
        end
    end

    // ---------------- stage c: alongside the bank read
    logic                vc_reg, kc_reg, inc_reg;
    logic [FRAC_W-1:0]   fxc_reg, fyc_reg, fzc_reg;
    logic [SAMPLE_W-1:0] pkc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= 1'b0;
        end
        else if (en)
        begin
            vc_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kc_reg  <= kb_reg;
            inc_reg <= inb_reg;
            fxc_reg <= fxb_reg;
            fyc_reg <= fyb_reg;
            fzc_reg <= fzb_reg;
            pkc_reg <= peak_reg;
        end
    end

    // ---------------- stage d: four blends along x
    logic                vd_reg, kd_reg, ind_reg;
    logic [FRAC_W-1:0]   fyd_reg, fzd_reg;
    logic [SAMPLE_W-1:0] pkd_reg;
    logic [SAMPLE_W-1:0] bx_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vd_reg <= 1'b0;
        end
        else if (en)
        begin
            vd_reg <= vc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kd_reg  <= kc_reg;
            ind_reg <= inc_reg;
            fyd_reg <= fyc_reg;
            fzd_reg <= fzc_reg;
            pkd_reg <= pkc_reg;
            for (int j = 0; j < 4; j++)
            begin
                bx_reg[j] <= blend(rd[2*j], rd[2*j+1], fxc_reg);
            end
        end
    end

    // ---------------- stage e: two blends along y
    logic                ve_reg, ke_reg, ine_reg;
    logic [FRAC_W-1:0]   fze_reg;
    logic [SAMPLE_W-1:0] pke_reg;
    logic [SAMPLE_W-1:0] by_reg [2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ve_reg <= 1'b0;
        end
        else if (en)
        begin
            ve_reg <= vd_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ke_reg    <= kd_reg;
            ine_reg   <= ind_reg;
            fze_reg   <= fzd_reg;
            pke_reg   <= pkd_reg;
            by_reg[0] <= blend(bx_reg[0], bx_reg[1], fyd_reg);
            by_reg[1] <= blend(bx_reg[2], bx_reg[3], fyd_reg);
        end
    end

    // ---------------- blend along z into the output register / skid entry
    logic                push, pop;
    logic [SAMPLE_W-1:0] dens;
    logic                ov_reg, oi_reg, si_reg;
    logic [SAMPLE_W-1:0] od_reg, op_reg, sd_reg, sp_reg;

    assign push = en && ve_reg && (ke_reg == KIND_QUERY);
    assign pop  = ov_reg && m_axis_tready;
    assign dens = ine_reg ? blend(by_reg[0], by_reg[1], fze_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
            sv_reg <= 1'b0;
        end
        else
        begin
            if (sv_reg)
            begin
                if (pop)
                begin
                    sv_reg <= 1'b0;
                end
            end
            else if (push)
            begin
                ov_reg <= 1'b1;
                sv_reg <= ov_reg && !pop;
            end
            else if (pop)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sv_reg)
        begin
            if (pop)
            begin
                od_reg <= sd_reg;
                oi_reg <= si_reg;
                op_reg <= sp_reg;
            end
        end
        else if (push)
        begin
            if (ov_reg && !pop)
            begin
                sd_reg <= dens;
                si_reg <= ine_reg;
                sp_reg <= pke_reg;
            end
            else
            begin
                od_reg <= dens;
                oi_reg <= ine_reg;
                op_reg <= pke_reg;
            end
        end
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = {op_reg, od_reg};
    assign m_axis_tuser  = oi_reg;

endmodule

`default_nettype wire

### design/tvs_ram.sv
// ----------------------------------------------------------------------------
// tvs_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module tvs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### design/tvs_axis.sv
// ----------------------------------------------------------------------------
// tvs_axis
// one axis: box test, scale to grid, pipelined restoring divide, cell split
// ----------------------------------------------------------------------------
`default_nettype none

module tvs_axis import tvs_pkg::*; #(
    parameter int G  = 16,
    parameter int QW = 20
) (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic signed [COORD_W-1:0]   pos,
    input  wire logic signed [COORD_W-1:0]   lo,
    input  wire logic signed [COORD_W-1:0]   hi,
    output logic                             in_box,
    output logic             [$clog2(G)-1:0] lower,
    output logic             [$clog2(G)-1:0] upper,
    output logic             [FRAC_W-1:0]    frac
);

    localparam int LW = $clog2(G);
    localparam int DW = COORD_W + 1;
    localparam int NW = DW + LW;
    localparam int XW = QW - FRAC_W;
    localparam logic [LW-1:0] GMAX = LW'(G - 1);

    // stage 1: offsets and box test
    logic [DW-1:0] d_reg, e_reg;
    logic          in1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg   <= DW'({pos[COORD_W-1], pos} - {lo[COORD_W-1], lo});
            e_reg   <= DW'({hi[COORD_W-1], hi} - {lo[COORD_W-1], lo});
            in1_reg <= (pos >= lo) && (pos <= hi);
        end
    end

    // stage 2: offset times cell count
    logic [NW-1:0] n_reg;
    logic [DW-1:0] e2_reg;
    logic          ez2_reg, in2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg   <= NW'(d_reg) * NW'(GMAX);
            e2_reg  <= e_reg;
            ez2_reg <= (e_reg == '0);
            in2_reg <= in1_reg;
        end
    end

    // divide stages, one quotient bit each
    logic [DW:0]   rem_w [QW+1];
    logic [QW-1:0] q_w   [QW+1];
    logic [QW-1:0] fd_w  [QW+1];
    logic [DW-1:0] e_w   [QW+1];
    logic          ez_w  [QW+1];
    logic          in_w  [QW+1];

    assign rem_w[0] = (DW+1)'(n_reg >> XW);
    assign q_w[0]   = '0;
    assign fd_w[0]  = {n_reg[XW-1:0], {FRAC_W{1'b0}}};
    assign e_w[0]   = e2_reg;
    assign ez_w[0]  = ez2_reg;
    assign in_w[0]  = in2_reg;

    for (genvar i = 0; i < QW; i++)
    begin : g_div
        logic [DW:0]   rem_reg;
        logic [QW-1:0] q_reg, fd_reg;
        logic [DW-1:0] e_reg_s;
        logic          ez_reg, in_reg;
        logic [DW:0]   trial;
        logic          ge;

        assign trial = {rem_w[i][DW-1:0], fd_w[i][QW-1]};
        assign ge    = trial >= {1'b0, e_w[i]};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg <= ge ? (trial - {1'b0, e_w[i]}) : trial;
                q_reg   <= {q_w[i][QW-2:0], ge};
                fd_reg  <= fd_w[i] << 1;
                e_reg_s <= e_w[i];
                ez_reg  <= ez_w[i];
                in_reg  <= in_w[i];
            end
        end

        assign rem_w[i+1] = rem_reg;
        assign q_w[i+1]   = q_reg;
        assign fd_w[i+1]  = fd_reg;
        assign e_w[i+1]   = e_reg_s;
        assign ez_w[i+1]  = ez_reg;
        assign in_w[i+1]  = in_reg;
    end

    // final stage: lower cell, clamped upper cell, fraction
    logic [QW-1:0] q;
    logic [XW-1:0] cell_q;
    logic [LW-1:0] low_c;
    logic [LW:0]   up_c;

    always_comb
    begin
        q      = ez_w[QW] ? '0 : q_w[QW];
        cell_q = q[QW-1:FRAC_W];
        low_c  = (cell_q > XW'(G - 1)) ? GMAX : LW'(cell_q);
        up_c   = {1'b0, low_c} + (LW+1)'(1);
        if (up_c >= (LW+1)'(G - 1))
        begin
            up_c = (LW+1)'(G - 1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_box <= in_w[QW];
            lower  <= low_c;
            upper  <= up_c[LW-1:0];
            frac   <= q[FRAC_W-1:0];
        end
    end

endmodule

`default_nettype wire

### design/tvs_checker.sv
// ----------------------------------------------------------------------------
// tvs_checker
// port-level checks on the volume sampler, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module tvs_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         cfg_valid,
    input wire logic         cfg_ready,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [31:0]  m_axis_tdata,
    input wire logic         m_axis_tuser
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // outside the box the density is zero
    a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[15:0] == 16'h0000)
        else $error("nonzero density outside box");

    // input only backs up behind a waiting result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && $past(m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output backpressure");

    // config channel never stalls
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write stalled");

endmodule

bind trilinear_volume_sampler tvs_checker u_tvs_checker (
    .clk(clk), .rst_n(rst_n), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .s_axis_tready(s_axis_tready),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);

`default_nettype wire
